### sv/heq_pkg.sv
// package of the histogram equalization table unit
// shared types and constants; no dependencies

package heq_pkg;

	localparam int PIX_W     = 16;
	localparam int BIN_W     = 8;
	localparam int LEVEL_W   = 8;
	localparam int APC_W     = 32;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 32;
	localparam int BIN_IDX_W = 10;
	localparam int NUM_W     = PIX_W + BIN_IDX_W;
	localparam int RANGE_CH  = 3;
	localparam int BINS_DEF  = 256;
	localparam int CHAN_DEF  = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN0  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN1  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN2  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX0  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX1  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX2  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_APC   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 4'd7;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_BUILD = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_CLEAR,
		CMD_ADD_BIN,
		CMD_ADD_DIV,
		CMD_BUILD,
		CMD_READ,
		CMD_READ_ZERO
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [1:0]             ch;
		logic [BIN_IDX_W-1:0]   bin;
		logic [NUM_W-1:0]       num;
		logic [PIX_W-1:0]       den;
	} cmd_t;

	typedef struct packed {
		logic [RANGE_CH-1:0][PIX_W-1:0] min_v;
		logic [RANGE_CH-1:0][PIX_W-1:0] max_v;
	} range_cfg_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

### sv/heq_if.sv
// item channels of the histogram equalization table unit
// request and response interfaces; no dependencies

interface heq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [1:0]  channel;
	logic [15:0] pixel;
	logic [7:0]  bin;

	modport source(output valid, output operation, output channel, output pixel,
		output bin, input ready);
	modport sink(input valid, input operation, input channel, input pixel,
		input bin, output ready);
endinterface

interface heq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] lut_value;

	modport source(output valid, output lut_value, input ready);
	modport sink(input valid, input lut_value, output ready);
endinterface

### sv/heq_fifo.sv
// two-entry command queue between front and back
// depends on heq_pkg

module heq_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  heq_pkg::cmd_t push_data,
	output logic         full,
	input  logic         pop,
	output logic         pop_valid,
	output heq_pkg::cmd_t pop_data
);
	import heq_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

### sv/heq_front.sv
// front: accepts items, decodes them and classifies pixels into commands
// depends on heq_pkg, heq_if

module heq_front #(
	parameter int BINS     = heq_pkg::BINS_DEF,
	parameter int CHANNELS = heq_pkg::CHAN_DEF
) (
	heq_req_if.sink              req,
	input  heq_pkg::range_cfg_t  range_cfg,
	input  logic [1:0]           n_active,
	input  heq_pkg::back_stat_t  stat,
	input  logic                 full,
	output logic                 push,
	output heq_pkg::cmd_t        push_data
);
	import heq_pkg::*;

	logic             accept;
	logic [1:0]       sel;
	logic [PIX_W-1:0] lo;
	logic [PIX_W-1:0] hi;
	logic [PIX_W-1:0] d;
	logic [PIX_W-1:0] r;

	assign req.ready = !full && !stat.init_busy;
	assign accept    = req.valid && req.ready;
	assign sel       = (req.channel == 2'd3) ? 2'd0 : req.channel;
	assign lo        = range_cfg.min_v[sel];
	assign hi        = range_cfg.max_v[sel];
	assign d         = req.pixel - lo;
	assign r         = hi - lo;

	always_comb begin
		push_data = '0;
		push      = 1'b0;
		unique case (op_t'(req.operation))
			OP_CLEAR: begin
				push_data.kind = CMD_CLEAR;
				push           = accept;
			end
			OP_ADD: begin
				push_data.ch = req.channel;
				push         = accept && (req.channel < n_active);
				if (hi <= lo || req.pixel <= lo) begin
					push_data.kind = CMD_ADD_BIN;
				end else if (d >= r) begin
					push_data.kind = CMD_ADD_BIN;
					push_data.bin  = BIN_IDX_W'(BINS - 1);
				end else begin
					push_data.kind = CMD_ADD_DIV;
					push_data.num  = NUM_W'(32'(d) * BINS);
					push_data.den  = r;
				end
			end
			OP_BUILD: begin
				push_data.kind = CMD_BUILD;
				push           = accept;
			end
			OP_READ: begin
				push_data.ch = req.channel;
				push         = accept;
				if (32'(req.channel) < CHANNELS && 32'(req.bin) < BINS) begin
					push_data.kind = CMD_READ;
					push_data.bin  = BIN_IDX_W'(req.bin);
				end else begin
					push_data.kind = CMD_READ_ZERO;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end
endmodule

### sv/heq_div.sv
// restoring divider, one quotient bit per cycle, shared by bin and level math
// no dependencies

module heq_div #(
	parameter  int LW = 8,
	localparam int CW = $clog2(LW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [32:0]   rem_init,
	input  logic [LW-1:0] low_init,
	input  logic [31:0]   divisor,
	input  logic [CW-1:0] steps,
	output logic          done,
	output logic [LW-1:0] quotient
);
	logic [32:0]   rem_q;
	logic [LW-1:0] low_q;
	logic [31:0]   div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   trial;
	logic          ge;

	assign trial    = {rem_q[31:0], low_q[LW-1]};
	assign ge       = (trial >= {1'b0, div_q});
	assign done     = done_q;
	assign quotient = low_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			low_q <= low_init;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, div_q}) : trial;
			low_q <= {low_q[LW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule

### sv/heq_back.sv
// back: sequencer over histogram and table memories: clearing, adds, build and read
// depends on heq_pkg, heq_if, heq_div

module heq_back #(
	parameter int BINS     = heq_pkg::BINS_DEF,
	parameter int CHANNELS = heq_pkg::CHAN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  heq_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	input  logic [heq_pkg::APC_W-1:0]  apc,
	input  logic [1:0]                 n_active,
	output heq_pkg::back_stat_t        stat,
	heq_rsp_if.source                  rsp
);
	import heq_pkg::*;

	localparam int DEPTH = CHANNELS * BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = $clog2(BINS);
	localparam int LW    = (BW > 8) ? BW : 8;
	localparam int CW    = $clog2(LW + 1);
	localparam int SW    = APC_W + BW;

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_ADIV, S_HRD, S_HWR, S_BRD, S_BSUM, S_BDIV, S_BWR,
		S_RRD, S_ROUT
	} state_t;

	state_t             state_q;
	logic               init_q;
	logic [AW-1:0]      addr_q;
	logic [1:0]         ch_q;
	logic [1:0]         k_q;
	logic [BW-1:0]      i_q;
	logic [SW-1:0]      sum_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic               zero_q;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] out_value_q;

	logic [31:0]        hist_mem [DEPTH];
	logic [LEVEL_W-1:0] lut_mem  [DEPTH];
	logic [31:0]        hist_rd_q;
	logic [LEVEL_W-1:0] lut_rd_q;

	logic               hist_we;
	logic [31:0]        hist_wdata;
	logic               lut_we;
	logic [LEVEL_W-1:0] lut_wdata;

	logic               div_start;
	logic [32:0]        div_rem;
	logic [LW-1:0]      div_low;
	logic [31:0]        div_den;
	logic [CW-1:0]      div_steps;
	logic               div_done;
	logic [LW-1:0]      div_q;

	logic [SW-1:0]      sum_next;
	logic               out_free;

	assign sum_next       = sum_q + SW'(hist_rd_q);
	assign out_free       = !out_valid_q || rsp.ready;
	assign cmd_pop        = (state_q == S_IDLE) && cmd_valid;
	assign stat.init_busy = init_q;
	assign rsp.valid      = out_valid_q;
	assign rsp.lut_value  = out_value_q;

	heq_div #(.LW(LW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.low_init (div_low),
		.divisor  (div_den),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		div_start  = 1'b0;
		div_rem    = '0;
		div_low    = '0;
		div_den    = '0;
		div_steps  = '0;
		hist_we    = 1'b0;
		hist_wdata = '0;
		lut_we     = 1'b0;
		lut_wdata  = '0;
		unique case (state_q)
			S_SWEEP: begin
				hist_we = 1'b1;
				lut_we  = 1'b1;
			end
			S_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_ADD_DIV) begin
					div_start = 1'b1;
					div_rem   = 33'(cmd.num >> BW);
					div_low   = LW'(cmd.num[BW-1:0]) << (LW - BW);
					div_den   = 32'(cmd.den);
					div_steps = CW'(BW);
				end
			end
			S_HWR: begin
				hist_we    = 1'b1;
				hist_wdata = hist_rd_q + 32'd1;
			end
			S_BSUM: begin
				if (sum_next < SW'(apc)) begin
					div_start = 1'b1;
					div_rem   = 33'(sum_next);
					div_den   = apc;
					div_steps = CW'(8);
				end
			end
			S_BWR: begin
				lut_we    = 1'b1;
				lut_wdata = lvl_q;
			end
			default: begin
				hist_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[addr_q] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (lut_we) begin
			lut_mem[addr_q] <= lut_wdata;
		end
		lut_rd_q <= lut_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			init_q      <= 1'b1;
			addr_q      <= '0;
			ch_q        <= '0;
			k_q         <= '0;
			i_q         <= '0;
			sum_q       <= '0;
			lvl_q       <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_ROUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (addr_q == AW'(DEPTH - 1)) begin
						addr_q  <= '0;
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						ch_q <= cmd.ch;
						unique case (cmd.kind)
							CMD_CLEAR: begin
								addr_q  <= '0;
								state_q <= S_SWEEP;
							end
							CMD_ADD_BIN: begin
								addr_q  <= AW'(32'(cmd.ch) * BINS + 32'(cmd.bin));
								state_q <= S_HRD;
							end
							CMD_ADD_DIV: begin
								state_q <= S_ADIV;
							end
							CMD_BUILD: begin
								addr_q  <= '0;
								k_q     <= '0;
								i_q     <= '0;
								sum_q   <= '0;
								state_q <= S_BRD;
							end
							CMD_READ: begin
								addr_q  <= AW'(32'(cmd.ch) * BINS + 32'(cmd.bin));
								zero_q  <= 1'b0;
								state_q <= S_RRD;
							end
							default: begin
								zero_q  <= 1'b1;
								state_q <= S_ROUT;
							end
						endcase
					end
				end
				S_ADIV: begin
					if (div_done) begin
						addr_q  <= AW'(32'(ch_q) * BINS + 32'(div_q[BW-1:0]));
						state_q <= S_HRD;
					end
				end
				S_HRD: begin
					state_q <= S_HWR;
				end
				S_HWR: begin
					state_q <= S_IDLE;
				end
				S_BRD: begin
					state_q <= S_BSUM;
				end
				S_BSUM: begin
					sum_q <= sum_next;
					if (sum_next >= SW'(apc)) begin
						lvl_q   <= LEVEL_MAX;
						state_q <= S_BWR;
					end else begin
						state_q <= S_BDIV;
					end
				end
				S_BDIV: begin
					if (div_done) begin
						lvl_q   <= div_q[LEVEL_W-1:0];
						state_q <= S_BWR;
					end
				end
				S_BWR: begin
					addr_q <= addr_q + AW'(1);
					if (i_q == BW'(BINS - 1)) begin
						i_q     <= '0;
						sum_q   <= '0;
						k_q     <= k_q + 2'd1;
						state_q <= (k_q + 2'd1 == n_active) ? S_IDLE : S_BRD;
					end else begin
						i_q     <= i_q + BW'(1);
						state_q <= S_BRD;
					end
				end
				S_RRD: begin
					state_q <= S_ROUT;
				end
				S_ROUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= zero_q ? '0 : lut_rd_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

### sv/histogram_equalization_lut_unit.sv
// top level of the histogram equalization table unit: registers, front, queue, back
// depends on heq_pkg, heq_if, heq_fifo, heq_front, heq_back
//
//  channel  dir  payload                          handshake
//  req      in   operation, channel, pixel, bin   valid/ready
//  rsp      out  lut_value                        valid/ready
//  cfg      in   cfg_index, cfg_wdata             cfg_we, no wait
//
// add: a histogram read then write, after a divide when the bin needs one
// build: per bin a histogram read, sum and compare, a divide if the sum is under apc, write
// clear and reset: one sweep over all CHANNELS*BINS entries of both memories
// after reset req.ready stays low for that sweep; config writes are taken always
// a two-entry queue lets the front accept while the back or rsp stalls

module histogram_equalization_lut_unit #(
	parameter int BINS     = heq_pkg::BINS_DEF,
	parameter int CHANNELS = heq_pkg::CHAN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	heq_req_if.sink                         req,
	heq_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [heq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [heq_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
	import heq_pkg::*;

	localparam logic [1:0] N_COLOR = (CHANNELS < RANGE_CH) ? 2'(CHANNELS) : 2'(RANGE_CH);

	range_cfg_t         range_q;
	logic [APC_W-1:0]   apc_q;
	logic               color_q;
	logic [1:0]         n_active;
	back_stat_t         stat;
	logic               push;
	cmd_t               push_data;
	logic               full;
	logic               pop;
	logic               pop_valid;
	cmd_t               pop_data;

	assign n_active = color_q ? N_COLOR : 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q.min_v <= '0;
			range_q.max_v <= '1;
			apc_q         <= '0;
			color_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN0:  range_q.min_v[0] <= cfg_wdata[PIX_W-1:0];
				CFG_MIN1:  range_q.min_v[1] <= cfg_wdata[PIX_W-1:0];
				CFG_MIN2:  range_q.min_v[2] <= cfg_wdata[PIX_W-1:0];
				CFG_MAX0:  range_q.max_v[0] <= cfg_wdata[PIX_W-1:0];
				CFG_MAX1:  range_q.max_v[1] <= cfg_wdata[PIX_W-1:0];
				CFG_MAX2:  range_q.max_v[2] <= cfg_wdata[PIX_W-1:0];
				CFG_APC:   apc_q            <= cfg_wdata[APC_W-1:0];
				CFG_COLOR: color_q          <= cfg_wdata[0];
				default: begin
					color_q <= color_q;
				end
			endcase
		end
	end

	heq_front #(.BINS(BINS), .CHANNELS(CHANNELS)) u_front (
		.req       (req),
		.range_cfg (range_q),
		.n_active  (n_active),
		.stat      (stat),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	heq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	heq_back #(.BINS(BINS), .CHANNELS(CHANNELS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_data),
		.cmd_pop   (pop),
		.apc       (apc_q),
		.n_active  (n_active),
		.stat      (stat),
		.rsp       (rsp)
	);
endmodule
